>>> sv/umsfat_pkg.sv
// Shared types, constants and reciprocal factors for the Unix-time-to-calendar converter.
// No dependencies; every other file of the block but umsfat_if.sv imports this package.
`timescale 1ns / 1ps

package umsfat_pkg;

  typedef enum logic [1:0] {
    REG_UTC_OFFSET = 2'd0,
    REG_LIMIT_LOW  = 2'd1,
    REG_LIMIT_HIGH = 2'd2
  } reg_idx_e;

  localparam logic signed [11:0] UTC_OFFSET_RST = 12'sd0;
  localparam logic signed [11:0] LIMIT_LOW_RST  = -12'sd720;
  localparam logic signed [11:0] LIMIT_HIGH_RST = 12'sd840;

  localparam logic [15:0] MS_PER_MIN = 16'd60000;

  // Day 0 of year 65536, counted from 1970-01-01.
  localparam logic [24:0] DAYS_LIMIT = 25'd23217004;
  localparam logic [63:0] LIMIT_MS   = 64'(DAYS_LIMIT) * 64'd86400000;

  // Milliseconds per day is 84375 * 1024.
  localparam logic [16:0] DAY_FRAC  = 17'd84375;
  localparam int unsigned DAY_SHIFT = 41;
  localparam logic [24:0] DAY_RCP   = 25'((64'd1 << DAY_SHIFT) / 64'(DAY_FRAC));

  localparam logic [19:0] EPOCH_SHIFT = 20'd719468;
  localparam logic [17:0] ERA_DAYS    = 18'd146097;

  localparam int unsigned ERA_SH    = 44;
  localparam logic [26:0] ERA_RCP   =
    27'(((64'd1 << ERA_SH) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS));
  localparam int unsigned D1460_SH  = 29;
  localparam logic [18:0] D1460_RCP = 19'(((64'd1 << D1460_SH) + 64'd1459) / 64'd1460);
  localparam int unsigned D36524_SH  = 34;
  localparam logic [18:0] D36524_RCP =
    19'(((64'd1 << D36524_SH) + 64'd36523) / 64'd36524);
  localparam int unsigned D365_SH   = 27;
  localparam logic [18:0] D365_RCP  = 19'(((64'd1 << D365_SH) + 64'd364) / 64'd365);
  localparam int unsigned D100_SH   = 16;
  localparam logic [9:0]  D100_RCP  = 10'(((64'd1 << D100_SH) + 64'd99) / 64'd100);
  localparam int unsigned D153_SH   = 19;
  localparam logic [11:0] D153_RCP  = 12'(((64'd1 << D153_SH) + 64'd152) / 64'd153);

  localparam int unsigned MS1000_SH  = 37;
  localparam logic [27:0] MS1000_RCP = 28'(((64'd1 << MS1000_SH) + 64'd999) / 64'd1000);
  localparam int unsigned SEC60_SH   = 23;
  localparam logic [17:0] SEC60_RCP  = 18'(((64'd1 << SEC60_SH) + 64'd59) / 64'd60);
  localparam int unsigned MIN60_SH   = 17;
  localparam logic [11:0] MIN60_RCP  = 12'(((64'd1 << MIN60_SH) + 64'd59) / 64'd60);

  localparam logic [3:0]  MI_JAN       = 4'd10;
  localparam logic [15:0] FAT_YEAR_MIN = 16'd1980;
  localparam logic [15:0] FAT_YEAR_MAX = 16'd2107;
  localparam logic [31:0] FAT_FLOOR    = (32'd1 << 21) | (32'd1 << 16);
  localparam logic [31:0] FAT_CEIL     = (32'd127 << 25) | (32'd12 << 21) | (32'd31 << 16) |
                                         (32'd23 << 11) | (32'd59 << 5) | 32'd29;

  typedef struct packed {
    logic        neg;
    logic [26:0] mag;
    logic        bad;
  } off_cfg_t;

  typedef struct packed {
    logic        bad;
    logic [24:0] days;
    logic [26:0] dms;
  } split_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millisecond;
  } tod_t;

  typedef struct packed {
    logic        bad;
    logic [16:0] yr;
    logic [3:0]  mi;
    logic [8:0]  doy;
  } civ_t;

  typedef struct packed {
    logic        valid_res;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic [31:0] fat_time;
  } res_t;

  // First day of each March-based month, counted from March 1.
  function automatic logic [8:0] mi_start(input logic [3:0] mi);
    logic [8:0] r;
    case (mi)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/umsfat_if.sv
// Valid/ready channel interfaces: input timestamp, calendar result and register writes.
// No dependencies.
`timescale 1ns / 1ps

interface umsfat_item_if;
  logic        valid;
  logic        ready;
  logic [63:0] unix_ms;

  modport source (output valid, output unix_ms, input ready);
  modport sink   (input valid, input unix_ms, output ready);
endinterface

interface umsfat_res_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [15:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [9:0]  millisecond;
  logic [31:0] fat_time;

  modport source (output valid, output valid_res, output year, output month, output day,
                  output hour, output minute, output second, output millisecond,
                  output fat_time, input ready);
  modport sink   (input valid, input valid_res, input year, input month, input day,
                  input hour, input minute, input second, input millisecond,
                  input fat_time, output ready);
endinterface

interface umsfat_cfg_if;
  logic               valid;
  logic               ready;
  logic [1:0]         index;
  logic signed [11:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/umsfat_split.sv
// Stages 1 to 5: offset addition, range check and split into days and ms of day.
// Depends on umsfat_pkg.
`timescale 1ns / 1ps

module umsfat_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [63:0]         unix_ms_i,
  input  umsfat_pkg::off_cfg_t ocfg_i,
  output logic                vld_o,
  output umsfat_pkg::split_t  split_o
);
  import umsfat_pkg::*;

  logic [4:0]  vld_q;

  logic [64:0] s1_sum;
  logic [64:0] s1_dif;
  logic [63:0] s1_ms_d;
  logic        s1_bad_d;
  logic [63:0] s1_ms_q;
  logic        s1_bad_q;

  logic [40:0] s2_n;
  logic [48:0] s2_pl_d;
  logic [41:0] s2_ph_d;
  logic [48:0] s2_pl_q;
  logic [41:0] s2_ph_q;
  logic [40:0] s2_n_q;
  logic [9:0]  s2_r10_q;
  logic        s2_bad_q;

  logic [65:0] s3_prod;
  logic [24:0] s3_q0_q;
  logic [40:0] s3_n_q;
  logic [9:0]  s3_r10_q;
  logic        s3_bad_q;

  logic [41:0] s4_qd_d;
  logic [41:0] s4_qd_q;
  logic [24:0] s4_q0_q;
  logic [40:0] s4_n_q;
  logic [9:0]  s4_r10_q;
  logic        s4_bad_q;

  logic [41:0] s5_diff;
  logic [17:0] s5_rem;
  logic        s5_fix;
  logic [17:0] s5_remf;
  split_t      s5_d;
  split_t      s5_q;

  assign s1_sum   = {1'b0, unix_ms_i} + 65'(ocfg_i.mag);
  assign s1_dif   = {1'b0, unix_ms_i} - 65'(ocfg_i.mag);
  assign s1_ms_d  = ocfg_i.neg ? s1_dif[63:0] : s1_sum[63:0];
  assign s1_bad_d = ocfg_i.bad | (ocfg_i.neg ? s1_dif[64] : s1_sum[64]);

  assign s2_n    = s1_ms_q[50:10];
  assign s2_pl_d = 49'(s2_n[23:0]) * 49'(DAY_RCP);
  assign s2_ph_d = 42'(s2_n[40:24]) * 42'(DAY_RCP);

  assign s3_prod = {s2_ph_q, 24'd0} + 66'(s2_pl_q);

  assign s4_qd_d = 42'(s3_q0_q) * 42'(DAY_FRAC);

  always_comb begin
    s5_diff   = {1'b0, s4_n_q} - s4_qd_q;
    s5_rem    = s5_diff[17:0];
    s5_fix    = s5_rem >= 18'(DAY_FRAC);
    s5_remf   = s5_fix ? (s5_rem - 18'(DAY_FRAC)) : s5_rem;
    s5_d.bad  = s4_bad_q;
    s5_d.days = s5_fix ? (s4_q0_q + 25'd1) : s4_q0_q;
    s5_d.dms  = {s5_remf[16:0], s4_r10_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_ms_q  <= s1_ms_d;
      s1_bad_q <= s1_bad_d;

      s2_pl_q  <= s2_pl_d;
      s2_ph_q  <= s2_ph_d;
      s2_n_q   <= s2_n;
      s2_r10_q <= s1_ms_q[9:0];
      s2_bad_q <= s1_bad_q | (s1_ms_q >= LIMIT_MS);

      s3_q0_q  <= s3_prod[65:41];
      s3_n_q   <= s2_n_q;
      s3_r10_q <= s2_r10_q;
      s3_bad_q <= s2_bad_q;

      s4_qd_q  <= s4_qd_d;
      s4_q0_q  <= s3_q0_q;
      s4_n_q   <= s3_n_q;
      s4_r10_q <= s3_r10_q;
      s4_bad_q <= s3_bad_q;

      s5_q     <= s5_d;
    end
  end

  assign vld_o   = vld_q[4];
  assign split_o = s5_q;

endmodule

>>> sv/umsfat_clock.sv
// Stages 6 to 11 of the time-of-day path: hour, minute, second and millisecond.
// Depends on umsfat_pkg.
`timescale 1ns / 1ps

module umsfat_clock (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [26:0]       dms_i,
  output umsfat_pkg::tod_t  tod_o
);
  import umsfat_pkg::*;

  logic [54:0] s6_p;
  logic [16:0] s6_tsec_q;
  logic [26:0] s6_dms_q;

  logic [34:0] s7_p;
  logic [9:0]  s7_msec_q;
  logic [10:0] s7_tmin_q;
  logic [16:0] s7_tsec_q;

  logic [22:0] s8_p;
  logic [5:0]  s8_sec_q;
  logic [4:0]  s8_hour_q;
  logic [10:0] s8_tmin_q;
  logic [9:0]  s8_msec_q;

  tod_t        s9_d;
  tod_t        s9_q;
  tod_t        s10_q;
  tod_t        s11_q;

  assign s6_p = 55'(dms_i) * 55'(MS1000_RCP);
  assign s7_p = 35'(s6_tsec_q) * 35'(SEC60_RCP);
  assign s8_p = 23'(s7_tmin_q) * 23'(MIN60_RCP);

  always_comb begin
    s9_d.hour        = s8_hour_q;
    s9_d.minute      = 6'(s8_tmin_q - 11'(s8_hour_q) * 11'd60);
    s9_d.second      = s8_sec_q;
    s9_d.millisecond = s8_msec_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_tsec_q <= 17'(s6_p >> MS1000_SH);
      s6_dms_q  <= dms_i;

      s7_msec_q <= 10'(s6_dms_q - 27'(s6_tsec_q) * 27'd1000);
      s7_tmin_q <= 11'(s7_p >> SEC60_SH);
      s7_tsec_q <= s6_tsec_q;

      s8_sec_q  <= 6'(s7_tsec_q - 17'(s7_tmin_q) * 17'd60);
      s8_hour_q <= 5'(s8_p >> MIN60_SH);
      s8_tmin_q <= s7_tmin_q;
      s8_msec_q <= s7_msec_q;

      s9_q      <= s9_d;
      s10_q     <= s9_q;
      s11_q     <= s10_q;
    end
  end

  assign tod_o = s11_q;

endmodule

>>> sv/umsfat_date.sv
// Stages 6 to 11 of the date path: days to era, year of era, day of year and month index.
// Depends on umsfat_pkg.
`timescale 1ns / 1ps

module umsfat_date (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic                bad_i,
  input  logic [24:0]         days_i,
  output logic                vld_o,
  output umsfat_pkg::civ_t    civ_o
);
  import umsfat_pkg::*;

  logic [5:0]  vld_q;
  logic [4:0]  bad_q;

  logic [25:0] s6_z;
  logic [52:0] s6_p;
  logic [25:0] s6_z_q;
  logic [7:0]  s6_era_q;

  logic [17:0] s7_doe_q;
  logic [7:0]  s7_era_q;

  logic [36:0] s8_pa;
  logic [36:0] s8_pb;
  logic        s8_c;
  logic [17:0] s8_t_d;
  logic [17:0] s8_t_q;
  logic [17:0] s8_doe_q;
  logic [7:0]  s8_era_q;

  logic [36:0] s9_p;
  logic [8:0]  s9_yoe_q;
  logic [17:0] s9_doe_q;
  logic [7:0]  s9_era_q;

  logic [18:0] s10_p;
  logic [17:0] s10_base;
  logic [8:0]  s10_doy_q;
  logic [16:0] s10_yr_q;

  logic [10:0] s11_n;
  logic [22:0] s11_p;
  logic [3:0]  s11_mi;
  civ_t        s11_d;
  civ_t        s11_q;

  assign s6_z = 26'(days_i) + 26'(EPOCH_SHIFT);
  assign s6_p = 53'(s6_z) * 53'(ERA_RCP);

  assign s8_pa  = 37'(s7_doe_q) * 37'(D1460_RCP);
  assign s8_pb  = 37'(s7_doe_q) * 37'(D36524_RCP);
  assign s8_c   = s7_doe_q == (ERA_DAYS - 18'd1);
  assign s8_t_d = s7_doe_q - 18'(s8_pa >> D1460_SH) + 18'(s8_pb >> D36524_SH) - 18'(s8_c);

  assign s9_p = 37'(s8_t_q) * 37'(D365_RCP);

  assign s10_p    = 19'(s9_yoe_q) * 19'(D100_RCP);
  assign s10_base = 18'(s9_yoe_q) * 18'd365 + 18'(s9_yoe_q >> 2) - 18'(s10_p >> D100_SH);

  always_comb begin
    s11_n     = {s10_doy_q, 2'b00} + 11'(s10_doy_q) + 11'd2;
    s11_p     = 23'(s11_n) * 23'(D153_RCP);
    s11_mi    = 4'(s11_p >> D153_SH);
    s11_d.bad = bad_q[4];
    s11_d.yr  = s10_yr_q + 17'(s11_mi >= MI_JAN);
    s11_d.mi  = s11_mi;
    s11_d.doy = s10_doy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bad_q     <= {bad_q[3:0], bad_i};

      s6_z_q    <= s6_z;
      s6_era_q  <= 8'(s6_p >> ERA_SH);

      s7_doe_q  <= 18'(s6_z_q - 26'(s6_era_q) * 26'(ERA_DAYS));
      s7_era_q  <= s6_era_q;

      s8_t_q    <= s8_t_d;
      s8_doe_q  <= s7_doe_q;
      s8_era_q  <= s7_era_q;

      s9_yoe_q  <= 9'(s9_p >> D365_SH);
      s9_doe_q  <= s8_doe_q;
      s9_era_q  <= s8_era_q;

      s10_doy_q <= 9'(s9_doe_q - s10_base);
      s10_yr_q  <= 17'(s9_yoe_q) + 17'(s9_era_q) * 17'd400;

      s11_q     <= s11_d;
    end
  end

  assign vld_o = vld_q[5];
  assign civ_o = s11_q;

endmodule

>>> sv/umsfat_pack.sv
// Stage 12: month and day, final range check, FAT word packing and the output register.
// Depends on umsfat_pkg.
`timescale 1ns / 1ps

module umsfat_pack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  umsfat_pkg::civ_t  civ_i,
  input  umsfat_pkg::tod_t  tod_i,
  output logic              vld_o,
  output umsfat_pkg::res_t  res_o
);
  import umsfat_pkg::*;

  logic        vld_q;
  logic        bad;
  logic [15:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [31:0] fat;
  res_t        res_d;
  res_t        res_q;

  always_comb begin
    bad   = civ_i.bad | civ_i.yr[16];
    year  = civ_i.yr[15:0];
    month = (civ_i.mi < MI_JAN) ? (civ_i.mi + 4'd3) : (civ_i.mi - 4'd9);
    day   = 5'(civ_i.doy - mi_start(civ_i.mi) + 9'd1);
    if (year < FAT_YEAR_MIN) begin
      fat = FAT_FLOOR;
    end else if (year > FAT_YEAR_MAX) begin
      fat = FAT_CEIL;
    end else begin
      fat = {7'(year - FAT_YEAR_MIN), month, day, tod_i.hour, tod_i.minute,
             tod_i.second[5:1]};
    end
    if (bad) begin
      res_d          = '0;
      res_d.fat_time = FAT_FLOOR;
    end else begin
      res_d.valid_res   = 1'b1;
      res_d.year        = year;
      res_d.month       = month;
      res_d.day         = day;
      res_d.hour        = tod_i.hour;
      res_d.minute      = tod_i.minute;
      res_d.second      = tod_i.second;
      res_d.millisecond = tod_i.millisecond;
      res_d.fat_time    = fat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

endmodule

>>> sv/unix_ms_to_calendar_fat_time.sv
// Unix milliseconds to local calendar date, time of day and FAT word; uses umsfat_pkg.
// Each input transfer yields one result on the output register.
// Throughput: one transfer per cycle; the 12-stage pipeline holds as a whole only
// while a result waits on the output with ready low.
// Reset clears all valid bits and loads the offset, low-limit and high-limit registers with 0, -720 and 840.
`timescale 1ns / 1ps

module unix_ms_to_calendar_fat_time (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  umsfat_item_if.sink          item_i,
  umsfat_res_if.source         res_o,
  umsfat_cfg_if.sink           cfg_i
);
  import umsfat_pkg::*;

  logic signed [11:0] off_d;
  logic signed [11:0] off_q;
  logic signed [11:0] lo_d;
  logic signed [11:0] lo_q;
  logic signed [11:0] hi_d;
  logic signed [11:0] hi_q;
  logic [11:0]        cfg_mag;
  off_cfg_t           ocfg_d;
  off_cfg_t           ocfg_q;

  logic   en;
  logic   split_vld;
  split_t split;
  logic   civ_vld;
  civ_t   civ;
  tod_t   tod;
  logic   out_vld;
  res_t   res;

  always_comb begin
    off_d = off_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_UTC_OFFSET: off_d = cfg_i.data;
        REG_LIMIT_LOW:  lo_d  = cfg_i.data;
        REG_LIMIT_HIGH: hi_d  = cfg_i.data;
        default: ;
      endcase
    end
    cfg_mag     = off_d[11] ? 12'(~off_d + 12'd1) : 12'(off_d);
    ocfg_d.neg  = off_d[11];
    ocfg_d.mag  = 27'(28'(cfg_mag) * 28'(MS_PER_MIN));
    ocfg_d.bad  = (off_d < lo_d) || (off_d > hi_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= UTC_OFFSET_RST;
      lo_q   <= LIMIT_LOW_RST;
      hi_q   <= LIMIT_HIGH_RST;
      ocfg_q <= '0;
    end else begin
      off_q  <= off_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      ocfg_q <= ocfg_d;
    end
  end

  assign cfg_i.ready  = 1'b1;
  assign en           = !out_vld || res_o.ready;
  assign item_i.ready = en;

  umsfat_split u_split (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (item_i.valid),
    .unix_ms_i (item_i.unix_ms),
    .ocfg_i    (ocfg_q),
    .vld_o     (split_vld),
    .split_o   (split)
  );

  umsfat_date u_date (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (split_vld),
    .bad_i  (split.bad),
    .days_i (split.days),
    .vld_o  (civ_vld),
    .civ_o  (civ)
  );

  umsfat_clock u_clock (
    .clk_i (clk_i),
    .en_i  (en),
    .dms_i (split.dms),
    .tod_o (tod)
  );

  umsfat_pack u_pack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (civ_vld),
    .civ_i  (civ),
    .tod_i  (tod),
    .vld_o  (out_vld),
    .res_o  (res)
  );

  assign res_o.valid       = out_vld;
  assign res_o.valid_res   = res.valid_res;
  assign res_o.year        = res.year;
  assign res_o.month       = res.month;
  assign res_o.day         = res.day;
  assign res_o.hour        = res.hour;
  assign res_o.minute      = res.minute;
  assign res_o.second      = res.second;
  assign res_o.millisecond = res.millisecond;
  assign res_o.fat_time    = res.fat_time;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.valid_res |->
      res_o.fat_time == FAT_FLOOR && res_o.year == 16'd0 && res_o.month == 4'd0 &&
      res_o.day == 5'd0 && res_o.millisecond == 10'd0)
    else $error("Rejected result carries nonzero date fields or a wrong FAT word.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.valid_res |->
      res_o.month >= 4'd1 && res_o.month <= 4'd12 && res_o.day != 5'd0 &&
      res_o.hour <= 5'd23 && res_o.minute <= 6'd59 && res_o.second <= 6'd59 &&
      res_o.millisecond <= 10'd999)
    else $error("Accepted result has a calendar or clock field out of range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.valid_res && res_o.year >= FAT_YEAR_MIN &&
      res_o.year <= FAT_YEAR_MAX |->
      res_o.fat_time[31:25] == 7'(res_o.year - FAT_YEAR_MIN) &&
      res_o.fat_time[24:21] == res_o.month && res_o.fat_time[20:16] == res_o.day)
    else $error("FAT word does not match the date fields of the result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |-> !item_i.ready)
    else $error("Input transfer allowed while the output register is stalled.");

endmodule

>>> tb/tb_unix_ms_to_calendar_fat_time.sv
// Self-checking testbench for unix_ms_to_calendar_fat_time: a directed set of timestamps,
// then random ones over many offset and limit settings. An internal calendar predictor
// checks every result. Depends on umsfat_pkg, umsfat_if.sv and the block's RTL.
`timescale 1ns / 1ps

module tb_unix_ms_to_calendar_fat_time;
  import umsfat_pkg::*;

  localparam logic [1:0]  REG_UNUSED = 2'd3;
  localparam logic [63:0] SEC_MS     = 64'd1000;
  localparam logic [63:0] HOUR_MS    = 64'd3600000;
  localparam logic [63:0] DAY_MS     = 64'd86400000;
  localparam logic [63:0] Y1980_MS   = 64'd315532800000;
  localparam logic [63:0] Y2108_MS   = 64'd4354819200000;
  localparam int          NUM_PHASES = 12;
  localparam int          PHASE_ITEMS = 96;
  localparam int          MAX_REPORTS = 10;

  logic clk_i;
  logic rst_ni;

  umsfat_item_if item_ch ();
  umsfat_res_if  res_ch ();
  umsfat_cfg_if  cfg_ch ();

  unix_ms_to_calendar_fat_time dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  logic signed [11:0] utc_off_q;
  logic signed [11:0] lim_lo_q;
  logic signed [11:0] lim_hi_q;

  logic [63:0] stamp_q[$];
  res_t        calendar_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_cnt;
  int n_items;
  int n_results;
  int n_valid;
  int n_settings;

  always #4 clk_i = ~clk_i;

  function automatic res_t civil_from_unix(input logic [63:0] ums);
    res_t        r;
    int          off;
    int          lo;
    int          hi;
    logic [63:0] shift_ms;
    logic [63:0] loc_ms;
    logic [63:0] days;
    logic [63:0] dms;
    logic [63:0] z;
    logic [63:0] era;
    logic [63:0] doe;
    logic [63:0] yoe;
    logic [63:0] doy;
    logic [63:0] mi;
    logic [63:0] yr;
    logic [63:0] mon;
    logic [63:0] dd;
    logic [63:0] hh;
    logic [63:0] mm;
    logic [63:0] ss;
    logic [63:0] fat;
    r = '0;
    r.fat_time = FAT_FLOOR;
    off = utc_off_q;
    lo = lim_lo_q;
    hi = lim_hi_q;
    if (off < lo || off > hi) return r;
    if (off < 0) begin
      shift_ms = 64'(-off) * 64'(MS_PER_MIN);
      if (ums < shift_ms) return r;
      loc_ms = ums - shift_ms;
    end else begin
      shift_ms = 64'(off) * 64'(MS_PER_MIN);
      if (ums > ~64'd0 - shift_ms) return r;
      loc_ms = ums + shift_ms;
    end
    days = loc_ms / DAY_MS;
    dms = loc_ms % DAY_MS;
    z = days + 64'(EPOCH_SHIFT);
    era = z / 64'(ERA_DAYS);
    doe = z - era * 64'(ERA_DAYS);
    yoe = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
    yr = yoe + era * 64'd400;
    doy = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
    mi = (64'd5 * doy + 64'd2) / 64'd153;
    if (mi >= 64'd10) yr = yr + 64'd1;
    if (yr > 64'd65535) return r;
    mon = (mi < 64'd10) ? mi + 64'd3 : mi - 64'd9;
    dd = doy - (64'd153 * mi + 64'd2) / 64'd5 + 64'd1;
    hh = dms / HOUR_MS;
    dms = dms % HOUR_MS;
    mm = dms / 64'(MS_PER_MIN);
    dms = dms % 64'(MS_PER_MIN);
    ss = dms / SEC_MS;
    r.valid_res = 1'b1;
    r.year = yr[15:0];
    r.month = mon[3:0];
    r.day = dd[4:0];
    r.hour = hh[4:0];
    r.minute = mm[5:0];
    r.second = ss[5:0];
    r.millisecond = 10'(dms % SEC_MS);
    if (yr < 64'(FAT_YEAR_MIN)) begin
      r.fat_time = FAT_FLOOR;
    end else if (yr > 64'(FAT_YEAR_MAX)) begin
      r.fat_time = FAT_CEIL;
    end else begin
      fat = ((yr - 64'd1980) << 25) | (mon << 21) | (dd << 16) | (hh << 11) | (mm << 5) |
            (ss / 64'd2);
      r.fat_time = fat[31:0];
    end
    return r;
  endfunction

  function automatic string fmt_res(input res_t r);
    return $sformatf("ok=%0d %0d-%0d-%0d %0d:%0d:%0d.%0d fat=%08h", r.valid_res, r.year,
                     r.month, r.day, r.hour, r.minute, r.second, r.millisecond, r.fat_time);
  endfunction

  function automatic logic [63:0] pick_stamp();
    logic [63:0] y;
    logic [63:0] days;
    int          off;
    off = utc_off_q;
    case ($urandom_range(10))
      0: pick_stamp = {$urandom, $urandom};
      1: pick_stamp = ~64'd0 - 64'($urandom_range(200000000));
      2: pick_stamp = 64'($urandom_range(200000000));
      3: pick_stamp = 64'($urandom_range(23217100)) * DAY_MS +
                      64'($urandom_range(86399999));
      4: pick_stamp = Y1980_MS - 2 * DAY_MS + 64'($urandom_range(345600000));
      5: pick_stamp = Y2108_MS - 2 * DAY_MS + 64'($urandom_range(345600000));
      6: pick_stamp = LIMIT_MS - 2 * DAY_MS + 64'($urandom_range(345600000));
      7: begin
        if ($urandom_range(1) == 0) y = 64'($urandom_range(655, 20)) * 64'd100;
        else y = 64'($urandom_range(65535, 1971));
        days = 64'd365 * y + y / 64'd4 - y / 64'd100 + y / 64'd400 - 64'd719470 +
               64'($urandom_range(4));
        pick_stamp = days * DAY_MS + 64'($urandom_range(86399999));
      end
      8: pick_stamp = 64'd946684800000 + ({$urandom, $urandom} % 64'd1262304000000);
      9: pick_stamp = 64'($urandom_range(60000)) * DAY_MS +
                      (($urandom_range(1) == 0) ? 64'd0 : DAY_MS - 64'd1);
      default: begin
        if (off < 0) pick_stamp = 64'(-off) * 64'(MS_PER_MIN) - 64'd1 +
                                  64'($urandom_range(2));
        else pick_stamp = ~64'd0 - 64'(off) * 64'(MS_PER_MIN) - 64'd1 +
                          64'($urandom_range(2));
      end
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_UTC_OFFSET: utc_off_q = val;
      REG_LIMIT_LOW:  lim_lo_q = val;
      REG_LIMIT_HIGH: lim_hi_q = val;
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_ch.valid <= 1'b0;
      item_ch.unix_ms <= '0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        void'(stamp_q.pop_front());
        calendar_q.push_back(civil_from_unix(item_ch.unix_ms));
        n_items++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (stamp_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item_ch.valid <= 1'b1;
          item_ch.unix_ms <= stamp_q[0];
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_t want;
      res_t got;
      if (res_ch.valid && res_ch.ready) begin
        got.valid_res = res_ch.valid_res;
        got.year = res_ch.year;
        got.month = res_ch.month;
        got.day = res_ch.day;
        got.hour = res_ch.hour;
        got.minute = res_ch.minute;
        got.second = res_ch.second;
        got.millisecond = res_ch.millisecond;
        got.fat_time = res_ch.fat_time;
        n_results++;
        if (calendar_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("Unexpected result transfer: %s", fmt_res(got));
        end else begin
          want = calendar_q.pop_front();
          if (want.valid_res) n_valid++;
          if (got.valid_res !== want.valid_res || got.year !== want.year ||
              got.month !== want.month || got.day !== want.day ||
              got.hour !== want.hour || got.minute !== want.minute ||
              got.second !== want.second || got.millisecond !== want.millisecond ||
              got.fat_time !== want.fat_time) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("Mismatch at result %0d: expected %s, got %s", n_results,
                       fmt_res(want), fmt_res(got));
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #(2_000_000);
    $display("FAIL unix_ms_to_calendar_fat_time");
    $finish;
  end

  initial begin
    logic signed [11:0] ph_off;
    logic signed [11:0] ph_lo;
    logic signed [11:0] ph_hi;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    item_ch.valid = 1'b0;
    item_ch.unix_ms = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    utc_off_q = UTC_OFFSET_RST;
    lim_lo_q = LIMIT_LOW_RST;
    lim_hi_q = LIMIT_HIGH_RST;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fail_cnt = 0;
    n_items = 0;
    n_results = 0;
    n_valid = 0;
    n_settings = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      ph_lo = -12'sd720;
      ph_hi = 12'sd840;
      case (p)
        1:  ph_off = 12'sd60;
        2:  ph_off = -12'sd720;
        3:  ph_off = 12'sd840;
        4:  begin ph_off = -12'sd2048; ph_lo = -12'sd2048; ph_hi = 12'sd2047; end
        5:  begin ph_off = 12'sd2047; ph_lo = -12'sd2048; ph_hi = 12'sd2047; end
        6:  begin ph_off = -12'sd1440; ph_lo = -12'sd1440; ph_hi = 12'sd1440; end
        7:  begin ph_off = 12'sd1440; ph_lo = -12'sd1440; ph_hi = 12'sd1440; end
        8:  begin ph_off = 12'sd0; ph_lo = 12'sd100; ph_hi = -12'sd100; end
        9:  ph_off = 12'sd900;
        10: ph_off = -12'sd721;
        default: begin
          ph_off = 12'($urandom_range(2880) - 1440);
          ph_lo = -12'sd1440;
          ph_hi = 12'sd1440;
        end
      endcase
      if (p > 0) begin
        write_reg(REG_UNUSED, 12'($urandom));
        write_reg(REG_LIMIT_LOW, ph_lo);
        write_reg(REG_LIMIT_HIGH, ph_hi);
        write_reg(REG_UTC_OFFSET, ph_off);
      end
      n_settings++;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (p == 0) begin
        stamp_q.push_back(64'd0);
        stamp_q.push_back(64'd1);
        stamp_q.push_back(64'd999);
        stamp_q.push_back(DAY_MS - 64'd1);
        stamp_q.push_back(Y1980_MS - 64'd1);
        stamp_q.push_back(Y1980_MS);
        stamp_q.push_back(64'd946684799999);
        stamp_q.push_back(64'd951782400000);
        stamp_q.push_back(64'd951868800000);
        stamp_q.push_back(64'd2147483647000);
        stamp_q.push_back(64'd2147483648123);
        stamp_q.push_back(64'd4107456000000);
        stamp_q.push_back(64'd4107542400000);
        stamp_q.push_back(Y2108_MS - 64'd1);
        stamp_q.push_back(Y2108_MS);
        stamp_q.push_back(LIMIT_MS - 64'd1);
        stamp_q.push_back(LIMIT_MS);
        stamp_q.push_back(64'h8000_0000_0000_0000);
        stamp_q.push_back(~64'd1);
        stamp_q.push_back(~64'd0);
      end
      repeat (PHASE_ITEMS) stamp_q.push_back(pick_stamp());
      while (stamp_q.size() != 0 || calendar_q.size() != 0) @(posedge clk_i);
    end

    repeat (40) @(posedge clk_i);
    $display("Sent %0d timestamps over %0d offset and limit settings with four idle patterns.",
             n_items, n_settings);
    $display("Received %0d results: %0d valid conversions, %0d rejected or out of range.",
             n_results, n_valid, n_results - n_valid);
    if (fail_cnt == 0 && calendar_q.size() == 0) begin
      $display("PASS unix_ms_to_calendar_fat_time");
    end else begin
      $display("FAIL unix_ms_to_calendar_fat_time");
    end
    $finish;
  end

endmodule

>>> files.f
sv/umsfat_pkg.sv
sv/umsfat_if.sv
sv/umsfat_split.sv
sv/umsfat_clock.sv
sv/umsfat_date.sv
sv/umsfat_pack.sv
sv/unix_ms_to_calendar_fat_time.sv
tb/tb_unix_ms_to_calendar_fat_time.sv
